[rtl/ps_adpcm_block_decoder_top_defines.svh]
// assertion macros for the ps adpcm block decoder
// used by the top level, no other dependencies
`ifndef PS_ADPCM_BLOCK_DECODER_TOP_DEFINES_SVH
`define PS_ADPCM_BLOCK_DECODER_TOP_DEFINES_SVH

// same-cycle implication
`define PSADPCM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PSADPCM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/psadpcm_pkg.sv]
// shared types, constants and coefficient tables for the ps adpcm decoder
// no dependencies
package psadpcm_pkg;

    localparam int BYTE_W     = 8;
    localparam int NIB_W      = 4;
    localparam int HIST_W     = 32;
    localparam int SMP_W      = 16;
    localparam int COEF_W     = 10;
    localparam int CNT_W      = $clog2(COEF_W);
    localparam int ACC_W      = 44;
    localparam int PRED_SHIFT = 7;
    localparam int SUM_W      = ACC_W - PRED_SHIFT;
    localparam int SHIFT_BASE = 28;
    localparam int SHAMT_W    = 5;

    localparam logic [NIB_W-1:0] POS_HEADER = 4'd0;
    localparam logic [NIB_W-1:0] POS_MUTE   = 4'd1;
    localparam logic [NIB_W-1:0] POS_FIRST  = 4'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_FIN
    } t_state;

    // request from the sequencer to the predictor
    typedef struct packed {
        logic              load;
        logic [NIB_W-1:0]  filter;
        logic [NIB_W-1:0]  shift;
        logic [NIB_W-1:0]  nib;
    } t_pred_ctrl;

    // first tap, unused filter indices give zero
    function automatic logic [COEF_W-1:0] coef_a(input logic [NIB_W-1:0] idx);
        logic [COEF_W-1:0] k;
        case (idx)
            4'd1:    k = 10'sh0F0;
            4'd2:    k = 10'sh1CC;
            4'd3:    k = 10'sh188;
            4'd4:    k = 10'sh1E8;
            default: k = '0;
        endcase
        return k;
    endfunction

    // second tap
    function automatic logic [COEF_W-1:0] coef_b(input logic [NIB_W-1:0] idx);
        logic [COEF_W-1:0] k;
        case (idx)
            4'd2:    k = -10'sd208;
            4'd3:    k = -10'sd220;
            4'd4:    k = -10'sd240;
            default: k = '0;
        endcase
        return k;
    endfunction

endpackage

[rtl/psadpcm_ifs.sv]
// valid/ready channel interfaces for the ps adpcm decoder
// depends on psadpcm_pkg
interface psadpcm_in_if;
    import psadpcm_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              channel;
    logic              restart;

    modport source (output valid, data_byte, channel, restart, input ready);
    modport sink   (input valid, data_byte, channel, restart, output ready);
endinterface

interface psadpcm_out_if;
    import psadpcm_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [SMP_W-1:0] sample;
    logic                    sample_channel;
    logic                    last;

    modport source (output valid, sample, sample_channel, last, input ready);
    modport sink   (input valid, sample, sample_channel, last, output ready);
endinterface

[rtl/psadpcm_pred.sv]
// two-tap predictor: bit-serial multiply over the coefficient bits, msb first,
// then rounding, nibble scaling and saturation; depends on psadpcm_pkg
module psadpcm_pred (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  psadpcm_pkg::t_pred_ctrl  i_ctrl,
    input  logic signed [31:0]       i_h1,
    input  logic signed [31:0]       i_h2,
    output logic                     o_done,
    output logic signed [31:0]       o_value
);
    import psadpcm_pkg::*;

    logic [COEF_W-1:0]       r_ka;
    logic [COEF_W-1:0]       r_kb;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [ACC_W-1:0] n_acc;
    logic [CNT_W-1:0]        r_cnt;
    logic                    r_busy;
    logic [NIB_W-1:0]        r_nib;
    logic [NIB_W-1:0]        r_shift;

    logic signed [ACC_W-1:0] w_pa;
    logic signed [ACC_W-1:0] w_pb;
    logic signed [ACC_W-1:0] w_part;
    logic signed [SUM_W-1:0] w_y;
    logic signed [SUM_W-1:0] w_yh;
    logic signed [SUM_W-1:0] w_pred;
    logic [SHAMT_W-1:0]      w_shamt;
    logic signed [31:0]      w_xs;
    logic signed [SUM_W-1:0] w_sum;
    logic                    w_in_range;

    // one coefficient bit of each tap per cycle
    always_comb begin
        w_pa   = r_ka[COEF_W-1] ? ACC_W'(i_h1) : '0;
        w_pb   = r_kb[COEF_W-1] ? ACC_W'(i_h2) : '0;
        w_part = w_pa + w_pb;
        // the sign bit of the coefficient weighs negative
        if (r_cnt == CNT_W'(COEF_W - 1)) begin
            n_acc = -w_part;
        end else begin
            n_acc = (r_acc <<< 1) + w_part;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_ctrl.load) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_cnt == '0) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_ka    <= coef_a(i_ctrl.filter);
            r_kb    <= coef_b(i_ctrl.filter);
            r_acc   <= '0;
            r_cnt   <= CNT_W'(COEF_W - 1);
            r_nib   <= i_ctrl.nib;
            r_shift <= i_ctrl.shift;
        end else if (r_busy) begin
            r_ka  <= r_ka << 1;
            r_kb  <= r_kb << 1;
            r_acc <= n_acc;
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // rounding, scaled nibble and saturation
    always_comb begin
        w_y        = SUM_W'(r_acc >>> PRED_SHIFT);
        w_yh       = w_y >>> 1;
        w_pred     = w_yh + $signed({{(SUM_W-1){1'b0}}, w_y[0]});
        w_shamt    = SHAMT_W'(SHIFT_BASE) - {1'b0, r_shift};
        w_xs       = $signed({{(32-NIB_W){r_nib[NIB_W-1]}}, r_nib}) <<< w_shamt;
        w_sum      = SUM_W'(w_xs) + w_pred;
        w_in_range = (&w_sum[SUM_W-1:31]) || !(|w_sum[SUM_W-1:31]);
        if (w_in_range) begin
            o_value = w_sum[31:0];
        end else if (w_sum[SUM_W-1]) begin
            o_value = 32'sh8000_0000;
        end else begin
            o_value = 32'sh7FFF_FFFF;
        end
    end

    assign o_done = !r_busy;

endmodule

[rtl/ps_adpcm_block_decoder_top.sv]
// ps adpcm block decoder, top level; depends on psadpcm_pkg, psadpcm_ifs, psadpcm_pred
// header and mute bytes are taken while idle and give no sample
// a data byte gives two samples, low nibble first, each from one run of the
// 10-bit serial predictor multiply; no new byte is taken until the second sample
// is loaded into the output register, and a stalled sample holds the sequencer
// synchronous active-low reset clears histories, block position and handshakes
`include "ps_adpcm_block_decoder_top_defines.svh"

module ps_adpcm_block_decoder_top (
    input  logic           i_clk,
    input  logic           i_rst_n,
    psadpcm_in_if.sink     i_in,
    psadpcm_out_if.source  o_out
);
    import psadpcm_pkg::*;

    // sequencer
    t_state r_state;
    t_state n_state;

    // block context latched from the header and mute bytes
    logic [NIB_W-1:0]  r_pos;
    logic [NIB_W-1:0]  r_shift;
    logic [NIB_W-1:0]  r_filter;
    logic              r_ch;
    logic              r_mute;
    logic [NIB_W-1:0]  r_hi_nib;
    logic              r_nib_sel;

    // prediction history per channel, newest and older
    logic [1:0][HIST_W-1:0] r_h1;
    logic [1:0][HIST_W-1:0] r_h2;

    // output register
    logic                    r_o_valid;
    logic signed [SMP_W-1:0] r_o_sample;
    logic                    r_o_ch;
    logic                    r_o_last;

    logic                    w_in_fire;
    logic                    w_in_ready;
    logic [NIB_W-1:0]        w_pos_eff;
    logic                    w_is_data;
    logic                    w_slot_free;
    logic                    w_out_load;
    logic                    w_hist_wr;
    logic                    w_pred_load;
    logic                    w_pred_done;
    logic signed [31:0]      w_pred_value;
    t_pred_ctrl              w_pred_ctrl;

    assign w_in_fire   = i_in.valid && w_in_ready;
    // a restart turns this byte into a header
    assign w_pos_eff   = i_in.restart ? POS_HEADER : r_pos;
    assign w_is_data   = (w_pos_eff != POS_HEADER) && (w_pos_eff != POS_MUTE);
    assign w_slot_free = !r_o_valid || o_out.ready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_fire && w_is_data) n_state = ST_MAC;
            end
            ST_MAC: begin
                if (w_pred_done) n_state = ST_FIN;
            end
            ST_FIN: begin
                if (w_slot_free) n_state = r_nib_sel ? ST_IDLE : ST_MAC;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        w_in_ready  = 1'b0;
        w_out_load  = 1'b0;
        w_hist_wr   = 1'b0;
        w_pred_load = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                w_in_ready  = 1'b1;
                w_pred_load = i_in.valid && w_is_data;
            end
            ST_MAC: begin
            end
            ST_FIN: begin
                w_out_load  = w_slot_free;
                w_hist_wr   = w_slot_free && !r_mute;
                // second nibble starts as soon as the first leaves
                w_pred_load = w_slot_free && !r_nib_sel;
            end
            default: begin
            end
        endcase
    end

    // low nibble comes straight from the request, high nibble from the held one
    always_comb begin
        w_pred_ctrl.load   = w_pred_load;
        w_pred_ctrl.filter = r_filter;
        w_pred_ctrl.shift  = r_shift;
        w_pred_ctrl.nib    = (r_state == ST_IDLE) ? i_in.data_byte[NIB_W-1:0]
                                                  : r_hi_nib;
    end

    psadpcm_pred u_pred (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_pred_ctrl),
        .i_h1    (r_h1[r_ch]),
        .i_h2    (r_h2[r_ch]),
        .o_done  (w_pred_done),
        .o_value (w_pred_value)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // block position and header fields
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= POS_HEADER;
            r_shift   <= '0;
            r_filter  <= '0;
            r_ch      <= 1'b0;
            r_mute    <= 1'b0;
            r_nib_sel <= 1'b0;
        end else begin
            if (w_in_fire) begin
                if (w_pos_eff == POS_HEADER) begin
                    r_shift  <= i_in.data_byte[NIB_W-1:0];
                    r_filter <= i_in.data_byte[BYTE_W-1:NIB_W];
                    r_ch     <= i_in.channel;
                    r_pos    <= POS_MUTE;
                end else if (w_pos_eff == POS_MUTE) begin
                    r_mute <= |i_in.data_byte[BYTE_W-1:NIB_W];
                    r_pos  <= POS_FIRST;
                end else begin
                    // wraps back to the header after the last byte
                    r_pos     <= r_pos + 1'b1;
                    r_nib_sel <= 1'b0;
                end
            end else if (w_out_load) begin
                r_nib_sel <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire && w_is_data) begin
            r_hi_nib <= i_in.data_byte[BYTE_W-1:NIB_W];
        end
    end

    // history: cleared by restart, shifted by each unmuted sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h1 <= '0;
            r_h2 <= '0;
        end else if (w_in_fire && i_in.restart) begin
            r_h1 <= '0;
            r_h2 <= '0;
        end else if (w_hist_wr) begin
            r_h2[r_ch] <= r_h1[r_ch];
            r_h1[r_ch] <= w_pred_value;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_out_load) begin
            r_o_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_o_sample <= r_mute ? '0 : w_pred_value[31:HIST_W-SMP_W];
            r_o_ch     <= r_ch;
            r_o_last   <= r_nib_sel;
        end
    end

    assign i_in.ready           = w_in_ready;
    assign o_out.valid          = r_o_valid;
    assign o_out.sample         = r_o_sample;
    assign o_out.sample_channel = r_o_ch;
    assign o_out.last           = r_o_last;

    // checks
    `PSADPCM_ASSERT_NEXT(a_mute_gives_zero, i_clk, i_rst_n, w_out_load && r_mute, o_out.sample == '0, "muted block gave a nonzero sample")
    `PSADPCM_ASSERT_NEXT(a_mute_keeps_hist, i_clk, i_rst_n, r_mute && !w_in_fire, $stable(r_h1) && $stable(r_h2), "muted block changed the history")
    `PSADPCM_ASSERT_NEXT(a_ctl_byte_no_work, i_clk, i_rst_n, w_in_fire && !w_is_data, r_state == ST_IDLE, "header or mute byte started a sample")
    `PSADPCM_ASSERT_NOW(a_fin_pred_done, i_clk, i_rst_n, r_state == ST_FIN, w_pred_done, "sample finished while the predictor was busy")

endmodule
